// ===== rtl/core/xyz_dimension_order_route_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the XYZ dimension-order route core
// Concurrent checks clocked on aclk and gated off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef XYZ_DIMENSION_ORDER_ROUTE_CORE_ASSERT_SVH
`define XYZ_DIMENSION_ORDER_ROUTE_CORE_ASSERT_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define XYZDOR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("xyzdor assertion failed");

// Expression must never be true outside reset.
`define XYZDOR_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("xyzdor forbidden condition seen");

`else

`define XYZDOR_ASSERT(label, prop)
`define XYZDOR_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== rtl/core/xyzdor_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xyzdor_pkg
// Grid sizes, field widths and controller/datapath interface types.
// ---------------------------------------------------------------------------
package xyzdor_pkg;

    localparam int SIZE_X = 8;
    localparam int SIZE_Y = 8;
    localparam int SIZE_Z = 8;

    localparam int TOTAL_NODES = SIZE_X * SIZE_Y * SIZE_Z;

    localparam int IDX_W = 10;

    localparam int CW_X = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int CW_Y = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
    localparam int CW_Z = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
    localparam int NODE_W = (TOTAL_NODES > 1) ? $clog2(TOTAL_NODES) : 1;

    localparam int S_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic load;   // capture a new source/destination pair
        logic emit;   // write the current node to the output register, advance
    } xyzdor_cmd_t;

    typedef struct packed {
        logic final_word;  // next emitted word closes the route
        logic out_free;    // output register can take a word this cycle
    } xyzdor_status_t;

endpackage

// ===== rtl/core/xyzdor_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xyzdor_ctrl
// Route sequencer: takes one request, then issues one emit per free output slot.
// ---------------------------------------------------------------------------
module xyzdor_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  xyzdor_pkg::xyzdor_status_t status,
    output xyzdor_pkg::xyzdor_cmd_t    cmd
);
    import xyzdor_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output slot, then emit one node
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.final_word) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/xyzdor_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xyzdor_datapath
// Coordinate registers, one-step walker and the registered output word.
// ---------------------------------------------------------------------------
`include "xyz_dimension_order_route_core_assert.svh"

module xyzdor_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  xyzdor_pkg::xyzdor_cmd_t     cmd,
    input  xyzdor_pkg::idx_t            source_index,
    input  xyzdor_pkg::idx_t            dest_index,
    output xyzdor_pkg::xyzdor_status_t  status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output xyzdor_pkg::idx_t            out_node_index,
    output logic                       out_last,
    output logic                       out_range_error
);
    import xyzdor_pkg::*;

    logic [CW_X-1:0] cur_x_reg, cur_x_next, goal_x_reg;
    logic [CW_Y-1:0] cur_y_reg, cur_y_next, goal_y_reg;
    logic [CW_Z-1:0] cur_z_reg, cur_z_next, goal_z_reg;
    logic            err_reg;

    logic            out_valid_reg, out_valid_next;
    idx_t            out_node_reg;
    logic            out_last_reg;
    logic            out_err_reg;

    logic            match_x, match_y, match_z, at_goal;
    logic [NODE_W-1:0] node_cur;

    assign match_x = (cur_x_reg == goal_x_reg);
    assign match_y = (cur_y_reg == goal_y_reg);
    assign match_z = (cur_z_reg == goal_z_reg);
    assign at_goal = match_x && match_y && match_z;

    // linear index: x fastest, then y, then z
    assign node_cur = NODE_W'(int'(cur_x_reg)
                      + SIZE_X * (int'(cur_y_reg) + SIZE_Y * int'(cur_z_reg)));

    assign status.final_word = at_goal || err_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // advance one unit along the first dimension still off the goal
    always_comb begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cur_z_next = cur_z_reg;
        if (!match_x) begin
            cur_x_next = (cur_x_reg < goal_x_reg) ? cur_x_reg + CW_X'(1)
                                                  : cur_x_reg - CW_X'(1);
        end else if (!match_y) begin
            cur_y_next = (cur_y_reg < goal_y_reg) ? cur_y_reg + CW_Y'(1)
                                                  : cur_y_reg - CW_Y'(1);
        end else if (!match_z) begin
            cur_z_next = (cur_z_reg < goal_z_reg) ? cur_z_reg + CW_Z'(1)
                                                  : cur_z_reg - CW_Z'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_x_reg  <= CW_X'(int'(source_index) % SIZE_X);
            cur_y_reg  <= CW_Y'((int'(source_index) / SIZE_X) % SIZE_Y);
            cur_z_reg  <= CW_Z'(int'(source_index) / (SIZE_X * SIZE_Y));
            goal_x_reg <= CW_X'(int'(dest_index) % SIZE_X);
            goal_y_reg <= CW_Y'((int'(dest_index) / SIZE_X) % SIZE_Y);
            goal_z_reg <= CW_Z'(int'(dest_index) / (SIZE_X * SIZE_Y));
            err_reg    <= (int'(source_index) >= TOTAL_NODES)
                       || (int'(dest_index) >= TOTAL_NODES);
        end else if (cmd.emit) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            cur_z_reg <= cur_z_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_node_reg <= err_reg ? '0 : IDX_W'(node_cur);
            out_last_reg <= at_goal || err_reg;
            out_err_reg  <= err_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_node_index  = out_node_reg;
    assign out_last        = out_last_reg;
    assign out_range_error = out_err_reg;

    // never overwrite a word the sink has not taken
    `XYZDOR_ASSERT_NEVER(a_no_overwrite, cmd.emit && out_valid_reg && !out_ready)
    // an emit short of the goal always moves the walker
    `XYZDOR_ASSERT(a_walk_moves, (cmd.emit && !at_goal && !err_reg) |=>
        !$stable({cur_x_reg, cur_y_reg, cur_z_reg}))
    // a range error word always closes its route
    `XYZDOR_ASSERT(a_err_is_last, (out_valid_reg && out_err_reg) |-> out_last_reg)
    // load and emit are exclusive
    `XYZDOR_ASSERT_NEVER(a_cmd_exclusive, cmd.load && cmd.emit)

endmodule

// ===== rtl/core/xyz_dimension_order_route_core.sv =====
`timescale 1ns / 1ps
// Start: a taken request loads the coordinate registers and the sequencer enters its
// emit state, which then registers the first node word in the output register.
// Throughput: one node word per cycle without backpressure, by the single-step walker;
// a route is 1+|dx|+|dy|+|dz| words, up to 22 at 8x8x8, and holds off new requests.
// Reset: synchronous, active-low aresetn clears the sequencer and output valid.
// ---------------------------------------------------------------------------
// xyz_dimension_order_route_core
// Streams the X-then-Y-then-Z path between two grid nodes as node index words.
// ---------------------------------------------------------------------------
module xyz_dimension_order_route_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [9:0] source_index, [19:10] dest_index, rest zero
    input  logic [xyzdor_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [9:0] node_index, rest zero
    output logic [xyzdor_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    // [0] range_error
    output logic [0:0]                         m_tuser
);
    import xyzdor_pkg::*;

    xyzdor_cmd_t    cmd;
    xyzdor_status_t status;
    idx_t           node_index;

    xyzdor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    xyzdor_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .source_index    (s_tdata[IDX_W-1:0]),
        .dest_index      (s_tdata[2*IDX_W-1:IDX_W]),
        .status          (status),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_node_index  (node_index),
        .out_last        (m_tlast),
        .out_range_error (m_tuser[0])
    );

    assign m_tdata = M_TDATA_W'(node_index);

endmodule
